// ===== rtl/ddo_pkg.sv =====
// Shared types, constants and the arctangent table for the odometry integrator.
package ddo_pkg;

    localparam int CORD_W   = 33;   // CORDIC datapath width, Q2.30 with headroom
    localparam int MUL_W    = 33;   // shared multiplier operand width
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ATAN_N   = 24;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef logic [ATAN_IDX_W-1:0] t_atan_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORD,
        S_M_TURN,
        S_M_VX,
        S_M_VY,
        S_M_HI,
        S_M_LO,
        S_M_PX,
        S_M_PY,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic {
        CFG_NOMINAL_PERIOD = 1'b0,
        CFG_TURN_GAIN      = 1'b1
    } t_cfg_idx;

    function automatic logic [31:0] atan_lut(input t_atan_idx idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives cos and sin in Q2.30.
module ddo_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [31:0]                          i_angle,
    output logic                                 o_done,
    output logic signed [ddo_pkg::CORD_W-1:0]    o_cos,
    output logic signed [ddo_pkg::CORD_W-1:0]    o_sin
);

    localparam int CW = $clog2(CORDIC_STEPS);

    logic                                r_busy, n_busy;
    logic [CW-1:0]                       r_iter, n_iter;
    logic                                r_flip, n_flip;
    logic signed [ddo_pkg::CORD_W-1:0]   r_x, n_x;
    logic signed [ddo_pkg::CORD_W-1:0]   r_y, n_y;
    logic signed [ddo_pkg::CORD_W-1:0]   r_z, n_z;

    logic signed [ddo_pkg::CORD_W-1:0]   sx, sy, at;
    logic [31:0]                         a_fold;
    logic                                flip;
    logic                                last;

    function automatic logic a_sum_msb(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h4000_0000;
        return t[31];
    endfunction

    assign last   = (r_iter == CW'(CORDIC_STEPS - 1));
    assign o_done = r_busy && last;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

    always_comb begin
        sx   = r_x >>> r_iter;
        sy   = r_y >>> r_iter;
        at   = $signed({1'b0, ddo_pkg::atan_lut(ddo_pkg::t_atan_idx'(r_iter))});
        // fold headings beyond a quarter turn by a half turn, negate at the end
        flip   = a_sum_msb(i_angle);
        a_fold = flip ? (i_angle + 32'h8000_0000) : i_angle;

        n_busy = r_busy;
        n_iter = r_iter;
        n_flip = r_flip;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_flip = flip;
            n_x    = ddo_pkg::CORDIC_GAIN;
            n_y    = '0;
            n_z    = $signed({a_fold[31], a_fold});
        end else if (r_busy) begin
            if (!r_z[ddo_pkg::CORD_W-1]) begin
                n_x = r_x - sy;
                n_y = r_y + sx;
                n_z = r_z - at;
            end else begin
                n_x = r_x + sy;
                n_y = r_y - sx;
                n_z = r_z + at;
            end
            n_iter = r_iter + 1'b1;
            if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_iter <= n_iter;
        end
        r_flip <= n_flip;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("cordic started while busy");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_start |=> !r_busy)
        else $error("cordic still busy after last step");

    a_iter_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && (r_iter == '0))
        else $error("cordic step count not cleared on start");

endmodule

// ===== rtl/ddo_mul.sv =====
// Shared signed multiplier with a registered product.
module ddo_mul (
    input  logic                                 i_clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_b,
    output logic signed [ddo_pkg::PROD_W-1:0]    o_p
);

    logic signed [ddo_pkg::PROD_W-1:0] r_p, n_p;

    assign n_p = i_a * i_b;
    assign o_p = r_p;

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

endmodule

// ===== rtl/diff_drive_odometry_integrator_unit.sv =====
// Differential-drive odometry integrator: sequencer, state and output registers.
// One word in flight: input stalls from accept until the result is taken on the output channel.
// The CORDIC iterations and the seven passes through the shared multiplier make up the work per word.
// Reset (synchronous, i_rst_n low): position and heading zero, first word uses nominal period,
// registers return to nominal_period 3277 and turn_gain 2756311592.
module diff_drive_odometry_integrator_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [23:0]  i_left_speed,
    input  logic signed [23:0]  i_right_speed_raw,
    input  logic [15:0]         i_elapsed_time,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [47:0]  o_pos_x,
    output logic signed [47:0]  o_pos_y,
    output logic [31:0]         o_heading,
    output logic signed [23:0]  o_vel_x,
    output logic signed [23:0]  o_vel_y,
    output logic signed [31:0]  o_turn_rate
);

    localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] POS_MIN = {1'b1, {47{1'b0}}};
    localparam logic signed [23:0] VEL_MAX = {1'b0, {23{1'b1}}};
    localparam logic signed [23:0] VEL_MIN = {1'b1, {23{1'b0}}};

    ddo_pkg::t_state r_state, n_state;

    logic [15:0]         r_nominal_period;
    logic [31:0]         r_turn_gain;
    logic                r_first_done;
    logic signed [47:0]  r_pos_x, n_pos_x;
    logic signed [47:0]  r_pos_y, n_pos_y;
    logic [31:0]         r_heading;
    logic signed [25:0]  r_sum, r_diff;
    logic [15:0]         r_dt;
    logic signed [25:0]  r_hi;
    logic [31:0]         r_lo;
    logic signed [23:0]  r_vx, r_vy;
    logic [31:0]         r_delta;

    logic                in_accept, out_accept;
    logic                cor_done;
    logic signed [ddo_pkg::CORD_W-1:0]  cor_cos, cor_sin;
    logic signed [ddo_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [ddo_pkg::PROD_W-1:0]  mul_p;
    logic signed [24:0]  vr;
    logic signed [23:0]  vel_sat;
    logic signed [24:0]  pos_step;
    logic signed [48:0]  pos_sum;
    logic signed [ddo_pkg::MUL_W-1:0]   dt_op;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != ddo_pkg::S_IDLE);
    assign o_out_valid = (r_state == ddo_pkg::S_OUT);
    assign o_cfg_ready = 1'b1;

    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_heading   = r_heading;
    assign o_vel_x     = r_vx;
    assign o_vel_y     = r_vy;
    assign o_turn_rate = 32'(r_hi);

    assign vr    = -$signed({i_right_speed_raw[23], i_right_speed_raw});
    assign dt_op = $signed({{(ddo_pkg::MUL_W-16){1'b0}}, r_dt});

    ddo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_angle (r_heading),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // floor of the registered velocity product by 2^31, saturated to 24 bits
    always_comb begin
        logic signed [34:0] v;
        v = mul_p[65:31];
        if (v > 35'(VEL_MAX)) begin
            vel_sat = VEL_MAX;
        end else if (v < 35'(VEL_MIN)) begin
            vel_sat = VEL_MIN;
        end else begin
            vel_sat = v[23:0];
        end
    end

    assign pos_step = mul_p[40:16];

    always_comb begin
        pos_sum = (r_state == ddo_pkg::S_M_PY) ? 49'(r_pos_x) + 49'(pos_step)
                                               : 49'(r_pos_y) + 49'(pos_step);
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (r_state == ddo_pkg::S_M_PY) begin
            if (pos_sum > 49'(POS_MAX)) begin
                n_pos_x = POS_MAX;
            end else if (pos_sum < 49'(POS_MIN)) begin
                n_pos_x = POS_MIN;
            end else begin
                n_pos_x = pos_sum[47:0];
            end
        end else if (r_state == ddo_pkg::S_FIN) begin
            if (pos_sum > 49'(POS_MAX)) begin
                n_pos_y = POS_MAX;
            end else if (pos_sum < 49'(POS_MIN)) begin
                n_pos_y = POS_MIN;
            end else begin
                n_pos_y = pos_sum[47:0];
            end
        end
    end

    // multiplier operand select and next state
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            ddo_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = ddo_pkg::S_CORD;
                end
            end
            ddo_pkg::S_CORD: begin
                if (cor_done) begin
                    n_state = ddo_pkg::S_M_TURN;
                end
            end
            ddo_pkg::S_M_TURN: begin
                mul_a   = ddo_pkg::MUL_W'(r_diff);
                mul_b   = $signed({1'b0, r_turn_gain});
                n_state = ddo_pkg::S_M_VX;
            end
            ddo_pkg::S_M_VX: begin
                mul_a   = ddo_pkg::MUL_W'(r_sum);
                mul_b   = cor_cos;
                n_state = ddo_pkg::S_M_VY;
            end
            ddo_pkg::S_M_VY: begin
                mul_a   = ddo_pkg::MUL_W'(r_sum);
                mul_b   = cor_sin;
                n_state = ddo_pkg::S_M_HI;
            end
            ddo_pkg::S_M_HI: begin
                mul_a   = ddo_pkg::MUL_W'(r_hi);
                mul_b   = dt_op;
                n_state = ddo_pkg::S_M_LO;
            end
            ddo_pkg::S_M_LO: begin
                mul_a   = $signed({1'b0, r_lo});
                mul_b   = dt_op;
                n_state = ddo_pkg::S_M_PX;
            end
            ddo_pkg::S_M_PX: begin
                mul_a   = ddo_pkg::MUL_W'(r_vx);
                mul_b   = dt_op;
                n_state = ddo_pkg::S_M_PY;
            end
            ddo_pkg::S_M_PY: begin
                mul_a   = ddo_pkg::MUL_W'(r_vy);
                mul_b   = dt_op;
                n_state = ddo_pkg::S_FIN;
            end
            ddo_pkg::S_FIN: begin
                n_state = ddo_pkg::S_OUT;
            end
            ddo_pkg::S_OUT: begin
                if (out_accept) begin
                    n_state = ddo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ddo_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal_period <= 16'd3277;
            r_turn_gain      <= 32'd2756311592;
            r_first_done     <= 1'b0;
            r_pos_x          <= '0;
            r_pos_y          <= '0;
            r_heading        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (ddo_pkg::t_cfg_idx'(i_cfg_index))
                    ddo_pkg::CFG_NOMINAL_PERIOD: r_nominal_period <= i_cfg_data[15:0];
                    ddo_pkg::CFG_TURN_GAIN:      r_turn_gain      <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            if (r_state == ddo_pkg::S_FIN) begin
                r_heading    <= r_heading + r_delta;
                r_first_done <= 1'b1;
            end
        end
    end

    // per-word datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sum  <= 26'(i_left_speed) + 26'(vr);
            r_diff <= 26'(vr) - 26'(i_left_speed);
            r_dt   <= r_first_done ? i_elapsed_time : r_nominal_period;
        end
        case (r_state)
            ddo_pkg::S_M_VX: begin
                r_hi <= mul_p[57:32];
                r_lo <= mul_p[31:0];
            end
            ddo_pkg::S_M_VY: r_vx <= vel_sat;
            ddo_pkg::S_M_HI: r_vy <= vel_sat;
            ddo_pkg::S_M_LO: r_delta <= mul_p[31:0];
            // add the carried-in fraction of the low half
            ddo_pkg::S_M_PX: r_delta <= r_delta + 32'(mul_p[47:32]);
            default: ;
        endcase
    end

    a_no_take_while_showing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_accept_starts_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ddo_pkg::S_CORD))
        else $error("accepted word did not start the rotation");

    a_cordic_done_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> (r_state == ddo_pkg::S_CORD))
        else $error("rotation finished outside its state");

    a_heading_only_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ddo_pkg::S_FIN) |=> $stable(r_heading))
        else $error("heading changed outside the update step");

endmodule
